[rtl/psfbl_pkg.sv]
`default_nettype none
package psfbl_pkg;

    localparam int DEF_TABLE_DEPTH    = 64;
    localparam int DEF_SWEEP_INTERVAL = 256;

    // item kinds carried on tuser
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_CHECK  = 2'd1;
    localparam logic [1:0] MODE_FAIL   = 2'd2;
    localparam logic [1:0] MODE_CREATE = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_MAX_ATT    = 3'd1;
    localparam logic [2:0] REG_WINDOW     = 3'd2;
    localparam logic [2:0] REG_INITIAL    = 3'd3;
    localparam logic [2:0] REG_MULT       = 3'd4;
    localparam logic [2:0] REG_MAX_DELAY  = 3'd5;
    localparam logic [2:0] REG_TTL        = 3'd6;

    localparam logic [15:0] FAIL_MAX  = 16'hFFFF;
    localparam logic [23:0] RETRY_MAX = 24'hFFFFFF;

    localparam int IN_W  = 104;
    localparam int OUT_W = 56;

    typedef struct packed {
        logic        enable;
        logic [15:0] max_attempts;
        logic [23:0] window;
        logic [23:0] initial_delay;
        logic [7:0]  mult;
        logic [23:0] max_delay;
        logic [23:0] ttl;
    } t_cfg;

    typedef struct packed {
        logic [31:0] address;
        logic [15:0] failures;
        logic [31:0] window_start;
        logic [31:0] last_access;
        logic [31:0] blocked_until;
        logic        bypass_valid;
        logic [63:0] bypass_hash;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic load;
        logic scan_cmp;
        logic miss;
        logic chk;
        logic upd;
        logic bo_step;
        logic wr;
        logic swcnt;
        logic sw_cmp;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic is_check;
        logic enable;
        logic hit;
        logic last;
        logic free_found;
        logic block;
        logic bo_done;
        logic sweep_due;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

[rtl/psfbl_ram.sv]
`default_nettype none
module psfbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/psfbl_ctrl.sv]
`default_nettype none
module psfbl_ctrl
    import psfbl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_RD    = 12'b0000_0000_0010,
        S_CMP   = 12'b0000_0000_0100,
        S_MISS  = 12'b0000_0000_1000,
        S_CHK   = 12'b0000_0001_0000,
        S_UPD   = 12'b0000_0010_0000,
        S_BO    = 12'b0000_0100_0000,
        S_WR    = 12'b0000_1000_0000,
        S_SWCNT = 12'b0001_0000_0000,
        S_SRD   = 12'b0010_0000_0000,
        S_SCMP  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_RD;
            S_RD: begin
                if (i_sts.is_tick || !i_sts.enable) n_state = S_DONE;
                else n_state = S_CMP;
            end
            S_CMP: begin
                priority if (i_sts.hit) n_state = i_sts.is_check ? S_CHK : S_UPD;
                else if (i_sts.last) n_state = i_sts.is_check ? S_DONE : S_MISS;
                else n_state = S_RD;
            end
            S_MISS:  n_state = i_sts.free_found ? S_UPD : S_SWCNT;
            S_CHK:   n_state = S_DONE;
            S_UPD:   n_state = i_sts.block ? S_BO : S_WR;
            S_BO:    if (i_sts.bo_done) n_state = S_WR;
            S_WR:    n_state = S_SWCNT;
            S_SWCNT: n_state = i_sts.sweep_due ? S_SRD : S_DONE;
            S_SRD:   n_state = S_SCMP;
            S_SCMP:  n_state = i_sts.last ? S_DONE : S_SRD;
            S_DONE:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.scan_cmp = (r_state == S_CMP);
    assign o_cmd.miss     = (r_state == S_MISS);
    assign o_cmd.chk      = (r_state == S_CHK);
    assign o_cmd.upd      = (r_state == S_UPD);
    assign o_cmd.bo_step  = (r_state == S_BO);
    assign o_cmd.wr       = (r_state == S_WR);
    assign o_cmd.swcnt    = (r_state == S_SWCNT);
    assign o_cmd.sw_cmp   = (r_state == S_SCMP);
    assign o_cmd.done     = (r_state == S_DONE);
endmodule
`default_nettype wire

[rtl/psfbl_dp.sv]
`default_nettype none
module psfbl_dp
    import psfbl_pkg::*;
#(
    parameter int TABLE_DEPTH    = DEF_TABLE_DEPTH,
    parameter int SWEEP_INTERVAL = DEF_SWEEP_INTERVAL
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire t_cmd             i_cmd,
    input  wire logic [1:0]       i_mode,
    input  wire logic [IN_W-1:0]  i_data,
    input  wire logic             i_out_ready,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output logic      [OUT_W-1:0] o_out_data
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(SWEEP_INTERVAL + 1);

    function automatic logic still_blocked(input logic [31:0] expiry, input logic [31:0] now);
        logic [31:0] d;
        d = expiry - now;
        return (d != 32'd0) && !d[31];
    endfunction

    // effective configuration
    logic [15:0] e_max_att;
    logic [23:0] e_window, e_initial, e_max_delay, e_ttl;
    logic [7:0]  e_mult;
    always_comb begin
        e_max_att   = (i_cfg.max_attempts == 16'd0) ? 16'd1 : i_cfg.max_attempts;
        e_window    = (i_cfg.window == 24'd0) ? 24'd1 : i_cfg.window;
        e_initial   = (i_cfg.initial_delay == 24'd0) ? 24'd1 : i_cfg.initial_delay;
        e_mult      = (i_cfg.mult == 8'd0) ? 8'd1 : i_cfg.mult;
        e_max_delay = (i_cfg.max_delay < e_initial) ? e_initial : i_cfg.max_delay;
        e_ttl       = (i_cfg.ttl < e_window) ? e_window : i_cfg.ttl;
    end

    logic [1:0]             r_mode;
    logic [31:0]            r_addr;
    logic [63:0]            r_hash;
    logic                   r_present;
    logic [31:0]            r_now;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [IW-1:0]          r_idx, r_free, r_sel;
    logic                   r_free_found;
    t_entry                 r_ent;
    logic [23:0]            r_delay;
    logic [15:0]            r_att;
    logic [CW-1:0]          r_cnt;
    logic                   r_blk, r_tfull;
    logic [24:0]            r_retry;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_data;

    t_entry     rdata, wdata;
    logic       we;
    logic [31:0] rem_d;
    logic        chk_blk, chk_bypass;
    logic        win_reset;
    logic [15:0] f0, f1;
    logic [31:0] prod;
    logic        swp_kill;
    logic [CW:0] cnt_inc;
    logic [ENTRY_W-1:0] ram_rdata;

    assign rdata = t_entry'(ram_rdata);

    psfbl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_sel),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        rem_d      = r_ent.blocked_until - r_now;
        chk_blk    = still_blocked(r_ent.blocked_until, r_now);
        chk_bypass = r_ent.bypass_valid && r_present && (r_ent.bypass_hash == r_hash);

        win_reset = (r_ent.failures == 16'd0) ||
                    ((r_now - r_ent.window_start) >= {8'd0, e_window});
        f0 = win_reset ? 16'd0 : r_ent.failures;
        f1 = (f0 == FAIL_MAX) ? f0 : f0 + 16'd1;

        prod = {8'd0, r_delay} * {24'd0, e_mult};

        swp_kill = r_valid[r_idx] && !still_blocked(rdata.blocked_until, r_now) &&
                   ((r_now - rdata.last_access) >= {8'd0, e_ttl});

        cnt_inc = {1'b0, r_cnt} + {{CW{1'b0}}, 1'b1};

        wdata = r_ent;
        if (i_cmd.chk) begin
            wdata.bypass_valid = 1'b0;
            wdata.bypass_hash  = 64'd0;
        end else if (r_delay != 24'd0) begin
            wdata.blocked_until = r_now + {8'd0, r_delay};
        end
        we = i_cmd.wr || (i_cmd.chk && chk_blk && chk_bypass);
    end

    always_comb begin
        o_sts.is_tick    = (r_mode == MODE_TICK);
        o_sts.is_check   = (r_mode == MODE_CHECK);
        o_sts.enable     = i_cfg.enable;
        o_sts.hit        = r_valid[r_idx] && (rdata.address == r_addr);
        o_sts.last       = (r_idx == IW'(TABLE_DEPTH - 1));
        o_sts.free_found = r_free_found;
        o_sts.block      = (f1 >= e_max_att);
        o_sts.bo_done    = (e_mult <= 8'd1) || (r_att >= r_ent.failures) ||
                           (r_delay >= e_max_delay);
        o_sts.sweep_due  = (cnt_inc >= (CW+1)'(SWEEP_INTERVAL));
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now        <= '0;
            r_valid      <= '0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx        <= '0;
                r_free_found <= 1'b0;
                if (i_mode == MODE_TICK) r_now <= r_now + 32'd1;
            end
            if (i_cmd.scan_cmp && !o_sts.hit) begin
                if (!r_free_found && !r_valid[r_idx]) r_free_found <= 1'b1;
                if (!o_sts.last) r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.wr) r_valid[r_sel] <= 1'b1;
            if (i_cmd.swcnt) begin
                r_cnt <= o_sts.sweep_due ? '0 : cnt_inc[CW-1:0];
                r_idx <= '0;
            end
            if (i_cmd.sw_cmp) begin
                if (swp_kill) r_valid[r_idx] <= 1'b0;
                if (!o_sts.last) r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.done && o_sts.out_free) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_addr    <= i_data[31:0];
            r_hash    <= i_data[95:32];
            r_present <= i_data[96];
            r_blk     <= 1'b0;
            r_tfull   <= 1'b0;
            r_retry   <= '0;
            r_delay   <= '0;
        end
        if (i_cmd.scan_cmp) begin
            if (o_sts.hit) begin
                r_ent <= rdata;
                r_sel <= r_idx;
            end else if (!r_free_found && !r_valid[r_idx]) begin
                r_free <= r_idx;
            end
        end
        if (i_cmd.miss) begin
            if (r_free_found) begin
                r_sel                <= r_free;
                r_ent.address        <= r_addr;
                r_ent.failures       <= 16'd0;
                r_ent.window_start   <= r_now;
                r_ent.last_access    <= r_now;
                r_ent.blocked_until  <= r_now;
                r_ent.bypass_valid   <= 1'b0;
                r_ent.bypass_hash    <= 64'd0;
            end else begin
                r_tfull <= 1'b1;
            end
        end
        if (i_cmd.chk && chk_blk && !chk_bypass) begin
            r_blk   <= 1'b1;
            r_retry <= {1'b0, (|rem_d[31:24]) ? RETRY_MAX : rem_d[23:0]} + 25'd1;
        end
        if (i_cmd.upd) begin
            r_ent.failures     <= f1;
            r_ent.window_start <= win_reset ? r_now : r_ent.window_start;
            r_ent.last_access  <= r_now;
            r_ent.bypass_valid <= (r_mode == MODE_CREATE) && r_present;
            r_ent.bypass_hash  <= ((r_mode == MODE_CREATE) && r_present) ? r_hash : 64'd0;
            r_delay            <= o_sts.block ? e_initial : 24'd0;
            r_att              <= e_max_att;
        end
        if (i_cmd.bo_step && !o_sts.bo_done) begin
            r_delay <= (prod > {8'd0, e_max_delay}) ? e_max_delay : prod[23:0];
            r_att   <= r_att + 16'd1;
        end
        if (i_cmd.done && o_sts.out_free) begin
            r_out_data <= {5'd0, r_tfull, r_delay, r_retry, r_blk};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule
`default_nettype wire

[rtl/per_source_failure_backoff_limiter.sv]
// Per-source login failure limiter with exponential backoff. Each input word is a tick
// (advances the seconds counter), a check (answers blocked / retry_after for a source) or a
// failure / account-creation record (counts failures in a fixed window and, at the limit,
// blocks the source for initial_delay times delay_multiplier per extra failure, capped at
// max_delay). Exactly one result word comes back per input word. One word is worked at a
// time: a tick or a word taken while disabled skips the lookup; a lookup walks the entry
// RAM one entry at a time, a read and then a compare per entry, and a record at the limit
// then runs the backoff, one multiply per cycle, at most 24 steps. Every SWEEP_INTERVAL-th
// record adds a sweep of the whole table that drops idle, unblocked entries. The lookup and
// the sweep read the entry RAM through its registered read port.
// The next word is taken while the previous result still waits in the output register.
// The user must write configuration only while idle; the block does not enforce it.
`default_nettype none
module per_source_failure_backoff_limiter
    import psfbl_pkg::*;
#(
    parameter int TABLE_DEPTH    = DEF_TABLE_DEPTH,
    parameter int SWEEP_INTERVAL = DEF_SWEEP_INTERVAL
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // config write port
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [23:0]       i_cfg_data,
    // input stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] source_address, [95:32] username_hash, [96] username_present, rest zero
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    // [1:0] mode
    input  wire logic [1:0]        s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // [0] blocked, [25:1] retry_after, [49:26] delay_applied, [50] table_full, rest zero
    output logic      [OUT_W-1:0]  m_axis_tdata
);
    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    // config registers; reset gives the documented defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b0;
            r_cfg.max_attempts  <= 16'd5;
            r_cfg.window        <= 24'd60;
            r_cfg.initial_delay <= 24'd30;
            r_cfg.mult          <= 8'd2;
            r_cfg.max_delay     <= 24'd3600;
            r_cfg.ttl           <= 24'd3600;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ENABLE:    r_cfg.enable        <= i_cfg_data[0];
                REG_MAX_ATT:   r_cfg.max_attempts  <= i_cfg_data[15:0];
                REG_WINDOW:    r_cfg.window        <= i_cfg_data;
                REG_INITIAL:   r_cfg.initial_delay <= i_cfg_data;
                REG_MULT:      r_cfg.mult          <= i_cfg_data[7:0];
                REG_MAX_DELAY: r_cfg.max_delay     <= i_cfg_data;
                REG_TTL:       r_cfg.ttl           <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    psfbl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    psfbl_dp #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .SWEEP_INTERVAL (SWEEP_INTERVAL)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_mode      (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    // a taken word keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after accept");

    // blocked and retry_after agree
    a_blocked_retry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[25:1] != 25'd0)))
        else $error("blocked flag and retry_after disagree");

    // a dropped record sets no block
    a_full_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[50] |-> (m_axis_tdata[49:26] == 24'd0) &&
        !m_axis_tdata[0])
        else $error("table_full result carries a delay");
endmodule
`default_nettype wire

[sim/backoff_checker.sv]
`default_nettype none
module backoff_checker
    import psfbl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [23:0]       i_cfg_data,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire logic [IN_W-1:0]   i_in_data,
    input  wire logic [1:0]        i_in_user,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic [OUT_W-1:0]  i_out_data,
    output int                     o_pending,
    output int                     o_errors
);
    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int SWEEP = DEF_SWEEP_INTERVAL;

    typedef struct packed {
        logic        table_full;
        logic [23:0] delay_applied;
        logic [24:0] retry_after;
        logic        blocked;
    } t_verdict;

    t_verdict verdict_q[$];

    // mirrored configuration
    logic        c_en;
    int unsigned c_max, c_win, c_init, c_mult, c_maxd, c_ttl;

    // mirrored table
    logic [31:0] now_s;
    logic        ev[DEPTH];
    logic [31:0] ea[DEPTH];
    int unsigned efail[DEPTH];
    logic [31:0] ews[DEPTH], ela[DEPTH], ebu[DEPTH];
    logic        ebv[DEPTH];
    logic [63:0] eh[DEPTH];
    int unsigned rec_count;

    function automatic int unsigned floor_at(int unsigned v, int unsigned lo);
        return v < lo ? lo : v;
    endfunction

    function automatic int lookup(logic [31:0] addr);
        for (int i = 0; i < DEPTH; i++)
            if (ev[i] && ea[i] == addr) return i;
        return -1;
    endfunction

    // seconds left on a block, zero when not blocked (signed wrap compare)
    function automatic logic [31:0] time_left(int i);
        logic [31:0] d;
        d = ebu[i] - now_s;
        return (d == 0 || d[31]) ? 32'd0 : d;
    endfunction

    function automatic t_verdict limiter_decide(logic [1:0] mode, logic [31:0] addr,
                                                logic [63:0] hash, logic present);
        t_verdict v;
        int i;
        logic [31:0] rem;
        int unsigned max_att, win, init, mult, maxd, ttl, delay;
        v = '0;
        if (mode == MODE_TICK) begin
            now_s = now_s + 1;
            return v;
        end
        if (!c_en) return v;
        if (mode == MODE_CHECK) begin
            i = lookup(addr);
            if (i < 0) return v;
            rem = time_left(i);
            if (rem == 0) return v;
            if (ebv[i] && present && eh[i] == hash) begin
                ebv[i] = 1'b0;   // one-time bypass used up
                return v;
            end
            if (rem > 32'hFFFFFF) rem = 32'hFFFFFF;
            v.blocked = 1'b1;
            v.retry_after = rem[24:0] + 25'd1;
            return v;
        end
        max_att = floor_at(c_max, 1);
        win     = floor_at(c_win, 1);
        init    = floor_at(c_init, 1);
        mult    = floor_at(c_mult, 1);
        maxd    = floor_at(c_maxd, init);
        ttl     = floor_at(c_ttl, win);
        delay   = 0;
        i = lookup(addr);
        if (i < 0) begin
            for (int k = 0; k < DEPTH; k++)
                if (!ev[k]) begin
                    i = k;
                    break;
                end
            if (i >= 0) begin
                ev[i] = 1'b1; ea[i] = addr; efail[i] = 0;
                ews[i] = now_s; ela[i] = now_s; ebu[i] = now_s;
                ebv[i] = 1'b0; eh[i] = '0;
            end
        end
        if (i < 0) begin
            v.table_full = 1'b1;
        end else begin
            if (efail[i] == 0 || (now_s - ews[i]) >= win) begin
                efail[i] = 0;
                ews[i] = now_s;
            end
            ela[i] = now_s;
            ebv[i] = (mode == MODE_CREATE) && present;
            eh[i]  = ebv[i] ? hash : 64'd0;
            if (efail[i] < 32'hFFFF) efail[i]++;
            if (efail[i] >= max_att) begin
                delay = init;
                if (mult > 1) begin
                    for (int unsigned a = max_att; a < efail[i] && delay < maxd; a++) begin
                        if (delay > maxd / mult) begin
                            delay = maxd;
                            break;
                        end
                        delay = delay * mult;
                        if (delay > maxd) delay = maxd;
                    end
                end
                ebu[i] = now_s + delay;
            end
            v.delay_applied = delay[23:0];
        end
        rec_count++;
        if (rec_count >= SWEEP) begin
            for (int k = 0; k < DEPTH; k++)
                if (ev[k] && time_left(k) == 0 && (now_s - ela[k]) >= ttl)
                    ev[k] = 1'b0;
            rec_count = 0;
        end
        return v;
    endfunction

    assign o_pending = verdict_q.size();

    always @(posedge i_clk) begin
        t_verdict got, want;
        if (!i_rst_n) begin
            c_en = 1'b0; c_max = 5; c_win = 60; c_init = 30;
            c_mult = 2; c_maxd = 3600; c_ttl = 3600;
            now_s = '0;
            rec_count = 0;
            for (int k = 0; k < DEPTH; k++) ev[k] = 1'b0;
            verdict_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ENABLE:    c_en   = i_cfg_data[0];
                    REG_MAX_ATT:   c_max  = 32'(i_cfg_data[15:0]);
                    REG_WINDOW:    c_win  = 32'(i_cfg_data);
                    REG_INITIAL:   c_init = 32'(i_cfg_data);
                    REG_MULT:      c_mult = 32'(i_cfg_data[7:0]);
                    REG_MAX_DELAY: c_maxd = 32'(i_cfg_data);
                    REG_TTL:       c_ttl  = 32'(i_cfg_data);
                    default: ;
                endcase
            end
            // retire first: a result never belongs to the word taken at the same edge
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[50:0];
                if (verdict_q.size() == 0) begin
                    $display("%0t: result word with none expected, actual %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want || i_out_data[OUT_W-1:51] !== '0) begin
                        $display("%0t: mismatch expected blk=%0d retry=%0d delay=%0d full=%0d",
                                 $time, want.blocked, want.retry_after,
                                 want.delay_applied, want.table_full);
                        $display("%0t:          actual blk=%0d retry=%0d delay=%0d full=%0d",
                                 $time, got.blocked, got.retry_after,
                                 got.delay_applied, got.table_full);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                verdict_q.push_back(limiter_decide(i_in_user, i_in_data[31:0],
                                                   i_in_data[95:32], i_in_data[96]));
        end
    end
endmodule
`default_nettype wire

[sim/testbench.sv]
`default_nettype none
module testbench;
    import psfbl_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [2:0]        cfg_index = REG_ENABLE;
    logic [23:0]       cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    // [31:0] source_address, [95:32] username_hash, [96] username_present
    logic [IN_W-1:0]   in_data = '0;
    // [1:0] mode
    logic [1:0]        in_user = MODE_TICK;
    logic              out_valid;
    logic              out_ready = 1'b0;
    // [0] blocked, [25:1] retry_after, [49:26] delay_applied, [50] table_full
    logic [OUT_W-1:0]  out_data;

    int pending, errors;
    int send_idle_pct = 0;   // chance per slot that the sender holds off
    int recv_idle_pct = 0;   // chance per cycle that the result side stalls

    logic [31:0] addr_pool[6] = '{32'h0, 32'hFFFF_FFFF, 32'hA5A5_5A5A,
                                  32'h1, 32'h8000_0000, 32'h1234_5678};
    logic [63:0] hash_pool[4] = '{64'h0, {64{1'b1}}, 64'hDEAD_BEEF_0BAD_F00D,
                                  64'h5555_AAAA_5555_AAAA};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    per_source_failure_backoff_limiter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .s_axis_tuser  (in_user),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data)
    );

    backoff_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_in_user   (in_user),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // result-side backpressure, changed on the falling edge
    always @(negedge i_clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // hard stop if the block hangs
    initial begin
        #40_000_000;
        $display("testbench failed");
        $finish;
    end

    // one input word; tvalid stays high afterwards until the next call or a drain
    task automatic send_word(logic [1:0] mode, logic [31:0] addr,
                             logic [63:0] hash, logic present);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_user  = mode;
        in_data  = {7'b0, present, hash, addr};
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    // hold off until every result is back; config may then be touched
    task automatic drain;
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_cfg(logic en, logic [15:0] att, logic [23:0] win, logic [23:0] init,
                            logic [7:0] mult, logic [23:0] maxd, logic [23:0] ttl);
        drain();
        write_reg(REG_ENABLE, {23'b0, en});
        write_reg(REG_MAX_ATT, {8'b0, att});
        write_reg(REG_WINDOW, win);
        write_reg(REG_INITIAL, init);
        write_reg(REG_MULT, {16'b0, mult});
        write_reg(REG_MAX_DELAY, maxd);
        write_reg(REG_TTL, ttl);
    endtask

    // mostly a handful of repeating sources so windows and blocks build up
    task automatic random_words(int n, int fresh_pct);
        logic [1:0]  mode;
        logic [31:0] addr;
        logic [63:0] hash;
        int          r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            mode = r < 20 ? MODE_TICK : r < 50 ? MODE_CHECK : r < 82 ? MODE_FAIL : MODE_CREATE;
            addr = ($urandom_range(99) < fresh_pct) ? $urandom
                                                    : addr_pool[$urandom_range(5)];
            hash = ($urandom_range(99) < 70) ? hash_pool[$urandom_range(3)]
                                             : {$urandom, $urandom};
            send_word(mode, addr, hash, $urandom_range(3) != 0);
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: small limits so blocking shows up fast
        load_cfg(1'b1, 16'd3, 24'd10, 24'd5, 8'd2, 24'd100, 24'd20);
        send_word(MODE_CHECK, addr_pool[2], hash_pool[0], 1'b0);        // unknown source
        repeat (3) send_word(MODE_FAIL, addr_pool[2], hash_pool[1], 1'b1);
        send_word(MODE_CHECK, addr_pool[2], hash_pool[1], 1'b1);        // now blocked
        send_word(MODE_FAIL, addr_pool[2], hash_pool[1], 1'b1);         // grows delay
        send_word(MODE_FAIL, addr_pool[2], hash_pool[1], 1'b1);
        send_word(MODE_CREATE, addr_pool[2], hash_pool[2], 1'b1);       // sets bypass
        send_word(MODE_CHECK, addr_pool[2], hash_pool[2], 1'b0);        // absent name: no match
        send_word(MODE_CHECK, addr_pool[2], hash_pool[3], 1'b1);        // wrong hash
        send_word(MODE_CHECK, addr_pool[2], hash_pool[2], 1'b1);        // bypass used
        send_word(MODE_CHECK, addr_pool[2], hash_pool[2], 1'b1);        // bypass gone
        send_word(MODE_CREATE, addr_pool[1], hash_pool[1], 1'b0);       // create, no name
        send_word(MODE_FAIL, addr_pool[1], {64{1'b1}}, 1'b1);
        send_word(MODE_CREATE, addr_pool[1], {64{1'b1}}, 1'b1);
        send_word(MODE_CHECK, addr_pool[1], {64{1'b1}}, 1'b1);
        repeat (6) send_word(MODE_TICK, 32'h0, 64'h0, 1'b0);
        send_word(MODE_CHECK, addr_pool[2], 64'h0, 1'b0);
        send_word(MODE_FAIL, addr_pool[0], 64'h0, 1'b0);
        drain();

        // sender idles lightly, receiver heavily
        send_idle_pct = 19;
        recv_idle_pct = 61;
        random_words(180, 10);

        // every register but enable at its low extreme
        load_cfg(1'b1, 16'd0, 24'd0, 24'd0, 8'd0, 24'd0, 24'd0);
        send_idle_pct = 61;
        recv_idle_pct = 19;
        random_words(90, 10);

        // high extremes: long blocks, saturated retry and delay
        load_cfg(1'b1, 16'd1, 24'hFF_FFFF, 24'hFF_FFFF, 8'hFF, 24'hFF_FFFF, 24'hFF_FFFF);
        random_words(60, 10);

        // no idling; flood fresh sources until the table overflows
        load_cfg(1'b1, 16'hFFFF, 24'd4, 24'd3, 8'd3, 24'd50, 24'd6);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int k = 0; k < 90; k++)
            send_word(MODE_FAIL, $urandom, {$urandom, $urandom}, 1'($urandom_range(1)));
        random_words(100, 5);

        // throttling off: ticks count, everything else is a no-op
        load_cfg(1'b0, 16'd2, 24'd8, 24'd4, 8'd4, 24'd40, 24'd8);
        random_words(30, 10);
        load_cfg(1'b1, 16'd2, 24'd8, 24'd4, 8'd4, 24'd40, 24'd8);
        random_words(30, 10);

        drain();
        repeat (300) @(negedge i_clk);
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/psfbl_pkg.sv
rtl/psfbl_ram.sv
rtl/psfbl_ctrl.sv
rtl/psfbl_dp.sv
rtl/per_source_failure_backoff_limiter.sv
sim/backoff_checker.sv
sim/testbench.sv
